// ===== sv/ffba_pkg.sv =====
package ffba_pkg;

    localparam int unsigned MIN_PAYLOAD = 8;

    typedef enum logic [1:0] {
        K_ALLOC   = 2'd0,
        K_RELEASE = 2'd1
    } t_kind_code;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_size;
        logic [15:0] released_offset;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [15:0] payload_offset;
        logic [11:0] free_blocks;
    } t_result;

    typedef enum logic [4:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_UNX_RD,
        S_UNX_WR,
        S_UNC_RD,
        S_UNC_WR,
        S_UNP_WR,
        S_SP1_RD,
        S_SP1_WR,
        S_SP2_RD,
        S_SP2_WR,
        S_PU_RD,
        S_PU_WR,
        S_PH_RD,
        S_PH_WR,
        S_DONE
    } t_state;

endpackage

// ===== sv/first_fit_block_allocator_core.sv =====
// Release: S_PU_RD, S_PU_WR, S_PH_RD, S_PH_WR, then o_done. Allocate of size 0 or with
// an empty list goes straight to o_done. Allocate: S_WALK_RD, then one header read per
// free-list block visited, then the unlink states, plus the split and push states when split.
// Busy throughout; no new item is taken until idle; busy drops the cycle after o_done.
// Reset (synchronous, active low) sets one free block, then writes the first block and
// end sentinel headers (S_INIT0, S_INIT1). o_done is high for a single cycle; no stall.
module first_fit_block_allocator_core #(
    parameter int ARENA_BYTES  = 65536, // power of two
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 8      // power of two
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ffba_pkg::t_item  i_item,
    output logic             o_done,
    output ffba_pkg::t_result o_result
);
    import ffba_pkg::*;

    localparam int AW    = $clog2(ARENA_BYTES);
    localparam int ALG   = $clog2(ALIGN_BYTES);
    localparam int NSLOT = ARENA_BYTES / ALIGN_BYTES;
    localparam int SW    = $clog2(NSLOT);
    localparam int STEPS = NSLOT + 1;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int HW    = 16 + 2 + 2 * SW;
    localparam logic [15:0] FIRST_SIZE = 16'(ARENA_BYTES - 2 * HEADER_BYTES);
    localparam logic [SW-1:0] SENT_SLOT =
        SW'(((ARENA_BYTES - HEADER_BYTES) % ARENA_BYTES) / ALIGN_BYTES);

    typedef struct packed {
        logic [15:0]   size;
        logic          has_prev;
        logic          has_next;
        logic [SW-1:0] prev;
        logic [SW-1:0] next;
    } t_hdr;

    t_state r_state, n_state;

    logic [SW-1:0] r_head;
    logic          r_hv;
    logic [11:0]   r_count;

    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_t;
    logic [16:0]   r_want;
    logic [CW-1:0] r_steps;
    t_hdr          r_h;
    logic          r_found;
    logic [15:0]   r_payload;

    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    t_hdr          ram_wdata, q;
    logic [HW-1:0] ram_q;

    ffba_ram #(.WIDTH(HW), .DEPTH(NSLOT)) u_hdr (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    assign q = t_hdr'(ram_q);

    // request normalization
    logic [16:0] w0, want_c;
    logic [16:0] rel_pos;
    logic [SW-1:0] rel_slot;
    assign w0     = (i_item.request_size < 16'(MIN_PAYLOAD)) ? 17'(MIN_PAYLOAD)
                                                             : {1'b0, i_item.request_size};
    assign want_c = (w0 + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
    assign rel_pos  = {1'b0, i_item.released_offset} - 17'(HEADER_BYTES);
    assign rel_slot = rel_pos[AW-1:ALG];

    logic hit, split;
    logic [15:0] rest;
    logic [17:0] t_pos;
    logic [16:0] pay_cur, pay_t;
    logic [CW-1:0] steps_inc;
    assign hit       = {1'b0, q.size} >= r_want;
    assign split     = {2'b00, r_h.size} > ({1'b0, r_want} + 18'(MIN_PAYLOAD + HEADER_BYTES));
    assign rest      = 16'({1'b0, r_h.size} - 17'(HEADER_BYTES) - r_want);
    assign t_pos     = 18'({r_cur, ALG'(0)}) + 18'(HEADER_BYTES) + 18'(rest);
    assign pay_cur   = 17'({r_cur, ALG'(0)}) + 17'(HEADER_BYTES);
    assign pay_t     = 17'({r_t, ALG'(0)}) + 17'(HEADER_BYTES);
    assign steps_inc = r_steps + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT0: n_state = S_INIT1;
            S_INIT1: n_state = S_IDLE;
            S_IDLE: begin
                if (start) begin
                    if (i_item.kind == K_RELEASE[0]) begin
                        n_state = (i_item.released_offset != 16'd0) ? S_PU_RD : S_DONE;
                    end else begin
                        n_state = (i_item.request_size != 16'd0 && r_hv) ? S_WALK_RD : S_DONE;
                    end
                end
            end
            S_WALK_RD: n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (hit) begin
                    n_state = S_UNX_RD;
                end else if (!q.has_next || steps_inc >= CW'(STEPS)) begin
                    n_state = S_DONE;
                end
            end
            S_UNX_RD: n_state = S_UNX_WR;
            S_UNX_WR: n_state = S_UNC_RD;
            S_UNC_RD: n_state = S_UNC_WR;
            S_UNC_WR: n_state = S_UNP_WR;
            S_UNP_WR: n_state = split ? S_SP1_RD : S_DONE;
            S_SP1_RD: n_state = S_SP1_WR;
            S_SP1_WR: n_state = S_SP2_RD;
            S_SP2_RD: n_state = S_SP2_WR;
            S_SP2_WR: n_state = S_PU_RD;
            S_PU_RD:  n_state = S_PU_WR;
            S_PU_WR:  n_state = S_PH_RD;
            S_PH_RD:  n_state = S_PH_WR;
            S_PH_WR:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // RAM control and ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = q;
        ram_raddr = r_cur;
        case (r_state)
            S_INIT0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{size: FIRST_SIZE, default: '0};
            end
            S_INIT1: begin
                ram_we    = 1'b1;
                ram_waddr = SENT_SLOT;
                ram_wdata = '0;
            end
            S_WALK_CHK: ram_raddr = q.next;
            S_UNX_RD:   ram_raddr = r_h.next;
            S_UNX_WR: begin
                ram_we    = r_h.has_next;
                ram_waddr = r_h.next;
                ram_wdata.has_prev = r_h.has_prev;
                ram_wdata.prev     = r_h.prev;
            end
            S_UNC_WR:   ram_raddr = q.prev;
            S_UNP_WR: begin
                ram_we    = r_h.has_prev;
                ram_waddr = r_h.prev;
                ram_wdata.has_next = r_h.has_next;
                ram_wdata.next     = r_h.next;
            end
            S_SP1_WR: begin
                ram_we         = 1'b1;
                ram_wdata.size = rest;
            end
            S_SP2_RD:   ram_raddr = r_t;
            S_SP2_WR: begin
                ram_we         = 1'b1;
                ram_waddr      = r_t;
                ram_wdata.size = r_want[15:0];
            end
            S_PU_WR: begin
                ram_we             = 1'b1;
                ram_wdata.has_next = r_hv;
                ram_wdata.next     = r_head;
                ram_wdata.has_prev = 1'b0;
                ram_wdata.prev     = '0;
            end
            S_PH_RD:    ram_raddr = r_head;
            S_PH_WR: begin
                ram_we             = r_hv;
                ram_waddr          = r_head;
                ram_wdata.has_prev = 1'b1;
                ram_wdata.prev     = r_cur;
            end
            default: ;
        endcase
    end

    always_comb begin
        busy     = (r_state != S_IDLE);
        o_done   = (r_state == S_DONE);
        o_result = '{found: r_found, payload_offset: r_payload, free_blocks: r_count};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
            r_head  <= '0;
            r_hv    <= 1'b1;
            r_count <= 12'd1;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_UNP_WR: begin
                    if (!r_h.has_prev) begin
                        r_hv   <= r_h.has_next;
                        r_head <= r_h.next;
                    end
                    r_count <= r_count - 12'd1;
                end
                S_PH_WR: begin
                    r_head  <= r_cur;
                    r_hv    <= 1'b1;
                    r_count <= r_count + 12'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_found   <= 1'b0;
                r_payload <= '0;
                r_want    <= want_c;
                r_steps   <= '0;
                if (i_item.kind == K_RELEASE[0]) begin
                    r_cur   <= rel_slot;
                    r_found <= (i_item.released_offset != 16'd0);
                end else begin
                    r_cur <= r_head;
                end
            end
            S_WALK_CHK: begin
                if (hit) begin
                    r_h <= q;
                end else begin
                    r_cur   <= q.next;
                    r_steps <= steps_inc;
                end
            end
            S_UNC_WR: r_h <= q;
            S_UNP_WR: begin
                r_found <= 1'b1;
                r_t     <= t_pos[AW-1:ALG];
                if (!split) begin
                    r_payload <= pay_cur[15:0];
                end
            end
            S_SP2_WR: r_payload <= pay_t[15:0];
            default: ;
        endcase
    end

endmodule

// ===== sv/ffba_ram.sv =====
module ffba_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
